// ===== rtl/m1ump_pkg.sv =====
// Shared types, codes and word builders for the MIDI 1.0 byte stream to UMP translator.
package m1ump_pkg;

  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_MTC      = 8'hF1;
  localparam logic [7:0] ST_SONG_POS = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] ST_TUNE     = 8'hF6;
  localparam logic [7:0] ST_RT_MIN   = 8'hF8;

  localparam logic [3:0] MT_SYSTEM  = 4'h1;
  localparam logic [3:0] MT_CHANNEL = 4'h2;
  localparam logic [3:0] MT_DATA64  = 4'h3;

  localparam logic [2:0] SX_MAX = 3'd6;

  localparam logic REG_GROUP = 1'b0;

  typedef enum logic [3:0] {
    SX_COMPLETE = 4'd0,
    SX_START    = 4'd1,
    SX_CONTINUE = 4'd2,
    SX_END      = 4'd3
  } sx_kind_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_LATER = 2'd2
  } sx_phase_e;

  typedef logic [6:0] data7_t;

  function automatic logic [31:0] msg_word(input logic [3:0] grp, input logic [7:0] st,
                                           input data7_t d1, input data7_t d2);
    logic [3:0] mt;
    mt = (st >= ST_SYSEX) ? MT_SYSTEM : MT_CHANNEL;
    return {mt, grp, st, 1'b0, d1, 1'b0, d2};
  endfunction

  function automatic logic one_data(input logic [7:0] st);
    return (st[7:4] == 4'hC) || (st[7:4] == 4'hD) || (st == ST_MTC) || (st == ST_SONG_SEL);
  endfunction

endpackage

// ===== rtl/midi1_bytestream_to_ump_unit.sv =====
// Top level of the MIDI 1.0 byte stream to UMP translator.
// Path: an accepted byte is registered in in_byte_q, then decoded into the output buffer obuf_q.
// Throughput: one byte per cycle while each byte makes at most one word and out_stall_i is low;
// a byte that makes more words (three at most) holds the decoder until the single-word output port drains.
// Reset: asynchronous, active low; clears running status, SysEx state, group and all valids.
module midi1_bytestream_to_ump_unit import m1ump_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] packet_word_o,
  output logic        last_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]  group_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic [7:0]  rs_q, rs_d;
  data7_t      fd_q, fd_d;
  logic        fdv_q, fdv_d;
  sx_phase_e   phase_q, phase_d;
  logic [2:0]  sx_cnt_q, sx_cnt_d;
  data7_t      sx_bytes_q [6];
  data7_t      sx_bytes_d [6];
  logic [31:0] obuf_q [3];
  logic [31:0] w0, w1, w2;
  logic [1:0]  out_cnt_q, n_words;

  logic        cfg_wr, take, buf_free, fire;
  logic        sx_emit, msg_emit;
  sx_kind_e    sx_kind;
  logic [7:0]  msg_st;
  data7_t      msg_d1, msg_d2;
  logic [2:0]  sx_idx;
  logic [31:0] sx_w0, sx_w1, m_w;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_GROUP);
  assign prdata = (paddr[2] == REG_GROUP) ? {28'd0, group_q} : 32'd0;

  assign out_valid_o   = (out_cnt_q != 2'd0);
  assign packet_word_o = obuf_q[0];
  assign last_word_o   = (out_cnt_q == 2'd1);
  assign take          = out_valid_o && !out_stall_i;
  assign buf_free      = (out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && !out_stall_i);
  assign fire          = in_valid_q && buf_free;
  assign in_stall_o    = in_valid_q && !buf_free;

  always_comb begin
    rs_d     = rs_q;
    fd_d     = fd_q;
    fdv_d    = fdv_q;
    phase_d  = phase_q;
    sx_cnt_d = sx_cnt_q;
    sx_emit  = 1'b0;
    sx_kind  = SX_COMPLETE;
    msg_emit = 1'b0;
    msg_st   = in_byte_q;
    msg_d1   = '0;
    msg_d2   = '0;
    sx_idx   = '0;
    for (int i = 0; i < 6; i++) begin
      sx_bytes_d[i] = sx_bytes_q[i];
    end
    if (in_byte_q[7]) begin
      if (in_byte_q >= ST_RT_MIN) begin
        msg_emit = 1'b1;
      end else begin
        rs_d  = in_byte_q;
        fd_d  = '0;
        fdv_d = 1'b0;
        unique case (phase_q)
          PH_FIRST: begin
            sx_emit = 1'b1;
            sx_kind = SX_COMPLETE;
          end
          PH_LATER: begin
            sx_emit = 1'b1;
            sx_kind = SX_END;
          end
          default: ;
        endcase
        if (sx_emit) begin
          phase_d  = PH_IDLE;
          sx_cnt_d = '0;
          for (int i = 0; i < 6; i++) begin
            sx_bytes_d[i] = '0;
          end
        end
        if (in_byte_q == ST_TUNE) begin
          msg_emit = 1'b1;
        end else if (in_byte_q == ST_SYSEX) begin
          phase_d  = PH_FIRST;
          sx_cnt_d = '0;
        end
      end
    end else if ((phase_q == PH_FIRST) || (phase_q == PH_LATER)) begin
      if (sx_cnt_q >= SX_MAX) begin
        sx_emit  = 1'b1;
        sx_kind  = (phase_q == PH_FIRST) ? SX_START : SX_CONTINUE;
        phase_d  = PH_LATER;
        sx_idx   = '0;
        sx_cnt_d = 3'd1;
        for (int i = 0; i < 6; i++) begin
          sx_bytes_d[i] = '0;
        end
      end else begin
        sx_idx   = sx_cnt_q;
        sx_cnt_d = sx_cnt_q + 3'd1;
      end
      for (int i = 0; i < 6; i++) begin
        if (sx_idx == 3'(i)) begin
          sx_bytes_d[i] = in_byte_q[6:0];
        end
      end
    end else if (fdv_q) begin
      msg_emit = 1'b1;
      msg_st   = rs_q;
      msg_d1   = fd_q;
      msg_d2   = in_byte_q[6:0];
      fdv_d    = 1'b0;
      fd_d     = '0;
    end else if (rs_q != 8'd0) begin
      if (one_data(rs_q)) begin
        msg_emit = 1'b1;
        msg_st   = rs_q;
        msg_d1   = in_byte_q[6:0];
      end else if ((rs_q < ST_SYSEX) || (rs_q == ST_SONG_POS)) begin
        fd_d  = in_byte_q[6:0];
        fdv_d = 1'b1;
      end
    end
  end

  assign sx_w0 = {MT_DATA64, group_q, sx_kind, 1'b0, sx_cnt_q,
                  1'b0, sx_bytes_q[0], 1'b0, sx_bytes_q[1]};
  assign sx_w1 = {1'b0, sx_bytes_q[2], 1'b0, sx_bytes_q[3],
                  1'b0, sx_bytes_q[4], 1'b0, sx_bytes_q[5]};
  assign m_w   = msg_word(group_q, msg_st, msg_d1, msg_d2);

  always_comb begin
    if (sx_emit) begin
      w0      = sx_w0;
      w1      = sx_w1;
      w2      = m_w;
      n_words = msg_emit ? 2'd3 : 2'd2;
    end else begin
      w0      = m_w;
      w1      = m_w;
      w2      = m_w;
      n_words = msg_emit ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q    <= '0;
      in_valid_q <= 1'b0;
      rs_q       <= '0;
      fd_q       <= '0;
      fdv_q      <= 1'b0;
      phase_q    <= PH_IDLE;
      sx_cnt_q   <= '0;
      out_cnt_q  <= '0;
      for (int i = 0; i < 6; i++) begin
        sx_bytes_q[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        group_q <= pwdata[3:0];
      end
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        rs_q      <= rs_d;
        fd_q      <= fd_d;
        fdv_q     <= fdv_d;
        phase_q   <= phase_d;
        sx_cnt_q  <= sx_cnt_d;
        out_cnt_q <= n_words;
        for (int i = 0; i < 6; i++) begin
          sx_bytes_q[i] <= sx_bytes_d[i];
        end
      end else if (take) begin
        out_cnt_q <= out_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= stream_byte_i;
    end
    if (fire) begin
      obuf_q[0] <= w0;
      obuf_q[1] <= w1;
      obuf_q[2] <= w2;
    end else if (take) begin
      obuf_q[0] <= obuf_q[1];
      obuf_q[1] <= obuf_q[2];
    end
  end

`ifndef ASSERT_OFF
  a_sx_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sx_cnt_q <= SX_MAX) else $error("SysEx byte count beyond six");

  a_idle_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (sx_cnt_q == 3'd0)) else $error("SysEx count left outside SysEx");

  a_fdv_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fdv_q |-> (rs_q[7] && (phase_q != PH_FIRST) && (phase_q != PH_LATER)))
    else $error("Pending data byte without running status");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && (out_cnt_q > 2'd1)) |-> in_stall_o)
    else $error("Input taken while several beats remain");

  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (out_cnt_q == 2'd1) && !fire) |=> !out_valid_o)
    else $error("Output beat appeared after the last one");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the MIDI 1.0 byte stream to UMP translator.
module tb_top import m1ump_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam logic [2:0]  GROUP_ADDR  = 3'(4 * REG_GROUP);

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } ump_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  stream_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] packet_word_o;
  logic        last_word_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  midi1_bytestream_to_ump_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .stream_byte_i (stream_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .packet_word_o (packet_word_o),
    .last_word_o   (last_word_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [7:0]  midi_bytes[$];
  ump_beat_t   pending_words[$];
  logic [31:0] step_words[$];

  logic [3:0]  group_cfg = 4'd0;
  logic [7:0]  run_status = 8'h00;
  data7_t      first_byte = '0;
  logic        first_pending = 1'b0;
  sx_phase_e   sysex_state = PH_IDLE;
  logic [2:0]  sysex_fill = 3'd0;
  data7_t      sysex_buf[6] = '{default: '0};

  logic        byte_taken = 1'b0;
  logic        send_idle = 1'b1;
  logic        recv_idle = 1'b1;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned long_hold = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;

  function automatic void add_byte(input logic [7:0] b);
    midi_bytes.insert(midi_bytes.size(), b);
  endfunction

  function automatic void add_word(input logic [31:0] w);
    step_words.insert(step_words.size(), w);
  endfunction

  function automatic void add_beat(input logic [31:0] w, input logic l);
    ump_beat_t beat;
    beat.word = w;
    beat.last = l;
    pending_words.insert(pending_words.size(), beat);
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] status_word(input logic [7:0] st, input data7_t d1,
                                              input data7_t d2);
    logic [3:0] mt;
    mt = (st >= ST_SYSEX) ? MT_SYSTEM : MT_CHANNEL;
    return (32'(mt) << 28) | (32'(group_cfg) << 24) | (32'(st) << 16) | (32'(d1) << 8)
           | 32'(d2);
  endfunction

  task automatic flush_sysex(input sx_kind_e kind);
    add_word({MT_DATA64, group_cfg, 4'(kind), 1'b0, sysex_fill,
              1'b0, sysex_buf[0], 1'b0, sysex_buf[1]});
    add_word({1'b0, sysex_buf[2], 1'b0, sysex_buf[3],
              1'b0, sysex_buf[4], 1'b0, sysex_buf[5]});
    sysex_buf   = '{default: '0};
    sysex_fill  = 3'd0;
    sysex_state = PH_IDLE;
  endtask

  task automatic translate_byte(input logic [7:0] b);
    step_words.delete();
    if (b[7]) begin
      if (b >= ST_RT_MIN) begin
        add_word(status_word(b, '0, '0));
      end else begin
        run_status    = b;
        first_byte    = '0;
        first_pending = 1'b0;
        if (sysex_state == PH_FIRST) flush_sysex(SX_COMPLETE);
        else if (sysex_state == PH_LATER) flush_sysex(SX_END);
        if (b == ST_TUNE) begin
          add_word(status_word(b, '0, '0));
        end else if (b == ST_SYSEX) begin
          sysex_state = PH_FIRST;
          sysex_fill  = 3'd0;
        end
      end
    end else if (sysex_state == PH_FIRST || sysex_state == PH_LATER) begin
      if (sysex_fill >= SX_MAX) begin
        flush_sysex(sysex_state == PH_FIRST ? SX_START : SX_CONTINUE);
        sysex_state = PH_LATER;
      end
      sysex_buf[sysex_fill] = b[6:0];
      sysex_fill++;
    end else if (first_pending) begin
      add_word(status_word(run_status, first_byte, b[6:0]));
      first_pending = 1'b0;
      first_byte    = '0;
    end else if (run_status != 8'h00) begin
      if (run_status[7:4] == 4'hC || run_status[7:4] == 4'hD ||
          run_status == ST_MTC || run_status == ST_SONG_SEL) begin
        add_word(status_word(run_status, b[6:0], '0));
      end else if (run_status < ST_SYSEX || run_status == ST_SONG_POS) begin
        first_byte    = b[6:0];
        first_pending = 1'b1;
      end
    end
    foreach (step_words[i])
      add_beat(step_words[i], (i == step_words.size() - 1));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      translate_byte(stream_byte_i);
      byte_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin : drive_bytes
    logic       nv;
    logic [7:0] nb;
    nv = in_valid_i;
    nb = stream_byte_i;
    if (byte_taken) begin
      nv = 1'b0;
      byte_taken = 1'b0;
    end
    if (!nv && rst_ni) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (midi_bytes.size() > 0) begin
        nv = 1'b1;
        nb = midi_bytes.pop_front();
        send_gap = send_idle ? gap_len() : 0;
      end
    end
    in_valid_i    <= nv;
    stream_byte_i <= nb;
  end

  always @(negedge clk_i) begin : drive_stall
    logic ns;
    ns = 1'b0;
    if (long_hold > 0) begin
      long_hold--;
      ns = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      ns = 1'b1;
    end else if (recv_idle && $urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
      ns = (stall_left > 0);
      if (ns) stall_left--;
    end
    out_stall_i <= ns;
  end

  always @(posedge clk_i) begin : check_words
    ump_beat_t exp_beat;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $error("unexpected beat: packet_word %h last_word %b", packet_word_o, last_word_o);
        err_cnt++;
      end else begin
        exp_beat = pending_words.pop_front();
        if (packet_word_o !== exp_beat.word) begin
          $error("packet_word: expected %h, got %h", exp_beat.word, packet_word_o);
          err_cnt++;
        end
        if (last_word_o !== exp_beat.last) begin
          $error("last_word: expected %b, got %b", exp_beat.last, last_word_o);
          err_cnt++;
        end
      end
    end
  end

  task automatic write_group(input logic [3:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GROUP_ADDR;
    pwdata  <= 32'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    group_cfg = val;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(val)) begin
      $error("prdata: expected %h, got %h", 32'(val), prdata);
      err_cnt++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (midi_bytes.size() > 0 || in_valid_i || pending_words.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [7:0] data_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'h7F;
    return 8'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] realtime_byte();
    return 8'($urandom_range(ST_RT_MIN, 8'hFF));
  endfunction

  task automatic queue_message();
    int unsigned pick, n;
    logic [7:0]  st;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      st = 8'($urandom_range(8'h80, 8'hEF));
      add_byte(st);
      n = $urandom_range(1, 3);
      repeat (n) begin
        repeat ((st[7:4] == 4'hC || st[7:4] == 4'hD) ? 1 : 2) begin
          if ($urandom_range(0, 15) == 0) add_byte(realtime_byte());
          add_byte(data_byte());
        end
      end
    end else if (pick < 60) begin
      add_byte(ST_SYSEX);
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 25) : $urandom_range(0, 13);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) add_byte(realtime_byte());
        add_byte(data_byte());
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) add_byte(8'hF7);
      else if (pick < 9) add_byte(8'($urandom_range(8'h80, 8'hF6)));
    end else if (pick < 75) begin
      st = 8'($urandom_range(ST_MTC, ST_TUNE));
      add_byte(st);
      if (st == ST_SONG_POS) n = 2 * $urandom_range(1, 2);
      else if (st == ST_MTC || st == ST_SONG_SEL) n = $urandom_range(1, 3);
      else n = $urandom_range(0, 2);
      repeat (n) add_byte(data_byte());
    end else if (pick < 85) begin
      add_byte(realtime_byte());
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned target;
    target = midi_bytes.size() + count;
    while (midi_bytes.size() < target) queue_message();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_group(4'hF);
    midi_bytes = '{8'h00, 8'h90, 8'h3C, 8'h7F, 8'h40, 8'h00, 8'hC5, 8'h7F, 8'hFF,
                   8'hF0, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h7F, 8'hFE,
                   8'hF6, 8'h45, 8'hF0, 8'hF7, 8'h45, 8'hF2, 8'h10, 8'h20,
                   8'hF1, 8'h11, 8'h12};
    wait_drained();

    write_group(4'h0);
    queue_random(110);
    wait_drained();

    // Receiver holds off while the sender keeps offering bytes back to back.
    write_group(4'($urandom_range(1, 14)));
    send_idle = 1'b0;
    long_hold = 300;
    queue_random(110);
    wait_drained();

    write_group(4'($urandom_range(0, 15)));
    recv_idle = 1'b0;
    queue_random(55);
    wait_drained();

    write_group(4'($urandom_range(0, 15)));
    send_idle = 1'b1;
    recv_idle = 1'b1;
    queue_random(55);
    wait_drained();
    repeat (10) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/m1ump_pkg.sv
rtl/midi1_bytestream_to_ump_unit.sv
dv/tb_top.sv
